@@ rtl/mhc_pkg.sv @@
package mhc_pkg;

  localparam int unsigned HdrBytes = 24;
  localparam int unsigned IdxW     = 5;

  localparam logic [IdxW-1:0] IdxMagicLast = IdxW'(3);
  localparam logic [IdxW-1:0] IdxTypeEnd   = IdxW'(6);
  localparam logic [IdxW-1:0] IdxVerEnd    = IdxW'(8);
  localparam logic [IdxW-1:0] IdxLenEnd    = IdxW'(12);
  localparam logic [IdxW-1:0] IdxLenLast   = IdxW'(11);
  localparam logic [IdxW-1:0] IdxTidEnd    = IdxW'(20);
  localparam logic [IdxW-1:0] IdxHdrLast   = IdxW'(HdrBytes - 1);
  localparam logic [IdxW-1:0] IdxHdrDone   = IdxW'(HdrBytes);

  localparam logic [31:0] MagicReset  = 32'h0000_0000;
  localparam logic [31:0] MaxLenReset = 32'h0100_0000;

  typedef enum logic [0:0] {
    CFG_EXPECTED_MAGIC = 1'b0,
    CFG_MAX_PAYLOAD    = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BADSUM    = 2'd1,
    ST_BADMAGIC  = 2'd2,
    ST_TOOLONG   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_DISCARD = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

endpackage

@@ rtl/message_header_checker.sv @@
// Message header checker.
// Bytes of a received message enter on the input channel (data_byte, first_byte,
// in_valid, in_stall), one beat per byte, with first_byte high on the first byte.
// The 24-byte header is parsed as it passes; the magic and the payload length are
// checked against the two configuration registers; the user must write them through
// cfg_write, cfg_index and cfg_data while no message is in flight (not enforced).
// One result beat leaves on the output channel (out_valid, out_stall) for each
// failed check or at the end of each message, carrying the status, the header
// fields but the magic, and the 32-bit byte sum.
// A beat accepted at an edge is held in the input register and is processed when
// the result register is free or being read; the result beat, if any, is then
// presented from the result register.
// One byte is taken every cycle while the receiver does not stall; the rate is set
// by the combinational logic between the input register and the result register.
// When the receiver stalls, the result register holds its beat and the input
// register holds the next byte, so in_stall is high while both are full and the
// receiver keeps stalling.
// Reset clears both handshake stages, returns the registers to a magic of zero and
// a maximum length of 16 MiB, and drops bytes until the next first byte.
module message_header_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] msg_type,
  output logic [15:0] version,
  output logic [31:0] payload_len,
  output logic [63:0] txn_id,
  output logic [31:0] received_checksum,
  output logic [31:0] computed_checksum
);

  logic [31:0] expected_magic;
  logic [31:0] max_payload_length;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_first;
  logic        s1_move;

  mhc_pkg::phase_t              phase, phase_next;
  logic [mhc_pkg::IdxW-1:0]     header_index, header_index_next;
  logic [31:0]                  payload_remaining, payload_remaining_next;
  logic [31:0]                  running_sum, running_sum_next;
  logic [31:0]                  magic_field, magic_field_next;
  logic [15:0]                  type_field, type_field_next;
  logic [15:0]                  version_field, version_field_next;
  logic [31:0]                  length_field, length_field_next;
  logic [63:0]                  transaction_field, transaction_field_next;
  logic [31:0]                  checksum_field, checksum_field_next;
  logic                         emit;
  mhc_pkg::status_t             emit_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic     <= mhc_pkg::MagicReset;
      max_payload_length <= mhc_pkg::MaxLenReset;
    end else if (cfg_write) begin
      case (mhc_pkg::cfg_idx_t'(cfg_index))
        mhc_pkg::CFG_EXPECTED_MAGIC: expected_magic     <= cfg_data;
        mhc_pkg::CFG_MAX_PAYLOAD:    max_payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte  <= data_byte;
      s1_first <= first_byte;
    end
  end

  always_comb begin
    logic [31:0] sum_add;
    logic [31:0] rem_dec;
    logic        sum_ok;

    phase_next             = phase;
    header_index_next      = header_index;
    payload_remaining_next = payload_remaining;
    running_sum_next       = running_sum;
    magic_field_next       = magic_field;
    type_field_next        = type_field;
    version_field_next     = version_field;
    length_field_next      = length_field;
    transaction_field_next = transaction_field;
    checksum_field_next    = checksum_field;
    emit                   = 1'b0;
    emit_status            = mhc_pkg::ST_OK;

    if (s1_first) begin
      phase_next             = mhc_pkg::PH_HEADER;
      header_index_next      = '0;
      payload_remaining_next = '0;
      running_sum_next       = '0;
      magic_field_next       = '0;
      type_field_next        = '0;
      version_field_next     = '0;
      length_field_next      = '0;
      transaction_field_next = '0;
      checksum_field_next    = '0;
    end

    sum_add = running_sum_next + {24'd0, s1_byte};
    rem_dec = payload_remaining_next - 32'd1;

    case (phase_next)
      mhc_pkg::PH_PAYLOAD: begin
        running_sum_next       = sum_add;
        payload_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = mhc_pkg::PH_DISCARD;
          emit       = 1'b1;
        end
      end
      mhc_pkg::PH_HEADER: begin
        if (header_index_next < mhc_pkg::IdxTypeEnd - mhc_pkg::IdxW'(2)) begin
          magic_field_next = {magic_field_next[23:0], s1_byte};
        end else if (header_index_next < mhc_pkg::IdxTypeEnd) begin
          type_field_next = {type_field_next[7:0], s1_byte};
        end else if (header_index_next < mhc_pkg::IdxVerEnd) begin
          version_field_next = {version_field_next[7:0], s1_byte};
        end else if (header_index_next < mhc_pkg::IdxLenEnd) begin
          length_field_next = {length_field_next[23:0], s1_byte};
        end else if (header_index_next < mhc_pkg::IdxTidEnd) begin
          transaction_field_next = {transaction_field_next[55:0], s1_byte};
        end else begin
          checksum_field_next = {checksum_field_next[23:0], s1_byte};
        end

        if (header_index_next < mhc_pkg::IdxTidEnd) begin
          running_sum_next = sum_add;
        end

        if (header_index_next == mhc_pkg::IdxMagicLast &&
            magic_field_next != expected_magic) begin
          phase_next  = mhc_pkg::PH_DISCARD;
          emit        = 1'b1;
          emit_status = mhc_pkg::ST_BADMAGIC;
        end else if (header_index_next == mhc_pkg::IdxLenLast &&
                     length_field_next > max_payload_length) begin
          phase_next  = mhc_pkg::PH_DISCARD;
          emit        = 1'b1;
          emit_status = mhc_pkg::ST_TOOLONG;
        end else if (header_index_next == mhc_pkg::IdxHdrLast) begin
          if (length_field_next == '0) begin
            phase_next = mhc_pkg::PH_DISCARD;
            emit       = 1'b1;
          end else begin
            payload_remaining_next = length_field_next;
            phase_next             = mhc_pkg::PH_PAYLOAD;
          end
        end

        header_index_next = header_index_next + mhc_pkg::IdxW'(1);
      end
      default: begin
        phase_next = mhc_pkg::PH_DISCARD;
      end
    endcase

    sum_ok = (checksum_field_next == '0) || (running_sum_next == checksum_field_next);
    if (emit && emit_status == mhc_pkg::ST_OK && !sum_ok) begin
      emit_status = mhc_pkg::ST_BADSUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= mhc_pkg::PH_DISCARD;
      header_index      <= '0;
      payload_remaining <= '0;
      running_sum       <= '0;
      magic_field       <= '0;
      type_field        <= '0;
      version_field     <= '0;
      length_field      <= '0;
      transaction_field <= '0;
      checksum_field    <= '0;
    end else if (s1_move) begin
      phase             <= phase_next;
      header_index      <= header_index_next;
      payload_remaining <= payload_remaining_next;
      running_sum       <= running_sum_next;
      magic_field       <= magic_field_next;
      type_field        <= type_field_next;
      version_field     <= version_field_next;
      length_field      <= length_field_next;
      transaction_field <= transaction_field_next;
      checksum_field    <= checksum_field_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && emit) begin
      status            <= emit_status;
      msg_type          <= type_field_next;
      version           <= version_field_next;
      payload_len       <= length_field_next;
      txn_id            <= transaction_field_next;
      received_checksum <= checksum_field_next;
      computed_checksum <= running_sum_next;
    end
  end

  // The payload phase is only entered once the whole header has been taken.
  a_payload_after_header: assert property (@(posedge clk) disable iff (rst)
    phase == mhc_pkg::PH_PAYLOAD |-> header_index == mhc_pkg::IdxHdrDone)
    else $error("payload phase with header not complete");

  // A message in its payload always has bytes left to take.
  a_payload_remaining: assert property (@(posedge clk) disable iff (rst)
    phase == mhc_pkg::PH_PAYLOAD |-> payload_remaining != '0)
    else $error("payload phase with no bytes remaining");

  // A processed byte that raises a report shows up as a result beat.
  a_emit_to_output: assert property (@(posedge clk) disable iff (rst)
    s1_move && emit |=> out_valid)
    else $error("report lost between input and result register");

  // Early error reports come before the later fields are captured (length or transaction id, and checksum).
  a_badmagic_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mhc_pkg::ST_BADMAGIC |->
      payload_len == '0 && received_checksum == '0)
    else $error("bad magic report with later fields set");

  a_toolong_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mhc_pkg::ST_TOOLONG |->
      txn_id == '0 && received_checksum == '0)
    else $error("length report with later fields set");

endmodule
